// ===== rtl/ffba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared sizes, status codes and register indexes of the first-fit block
// allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int HEAP_BYTES   = 1048576;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 21;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int USED_W = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W  = $clog2(HEAP_BYTES);
    // block ends and fit thresholds, no wrap
    localparam int SUM_W  = $clog2(longint'(HEAP_BYTES) + longint'(HEADER_BYTES)
                                   + (longint'(1) << LEN_W)) + 2;
    // query minus heap base, signed
    localparam int DIFF_W = ADDR_W + 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FIND  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PAYLOAD = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/ffba_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel: allocate or find beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffba_req_if;

    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [ffba_pkg::LEN_W-1:0]  request_size;
    logic [ffba_pkg::ADDR_W-1:0] query_address;

    modport source (
        output valid,
        output operation,
        output request_size,
        output query_address,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  request_size,
        input  query_address,
        output ready
    );

endinterface
`default_nettype wire

// ===== rtl/ffba_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel: one result beat per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffba_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [ffba_pkg::STATUS_W-1:0] status;
    logic [ffba_pkg::ADDR_W-1:0]   block_address;
    logic [ffba_pkg::ADDR_W-1:0]   data_address;
    logic [ffba_pkg::LEN_W-1:0]    block_payload;

    modport source (
        output valid,
        output status,
        output block_address,
        output data_address,
        output block_payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  block_address,
        input  data_address,
        input  block_payload,
        output ready
    );

endinterface
`default_nettype wire

// ===== rtl/first_fit_block_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap block allocator over an address-ordered linked block table.
// ----------------------------------------------------------------------------
// One request at a time. An item is taken when the block is idle, then the
// block chain is walked from the head entry at one table entry per cycle:
// the offset/length memory and the link memory are both read at the entry
// whose index the previous read returned. An allocate that places a block
// passes through the walk, link and done states; an allocate that runs past
// the heap end and a find go from walk to done, and an allocate on a full
// table goes from idle straight to done. The result sits in an output
// register, so the next request is taken while the previous result still
// waits to be read; a second result waits in the last cycle of its item until
// the first is read. There is no clearing pass after reset. Register writes
// are taken at any time but must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ffba_req_if.sink                               req,
    ffba_rsp_if.source                             rsp,
    input  wire logic                              cfg_we,
    input  wire logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ffba_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W  = ffba_pkg::IDX_W;
    localparam int OFF_W  = ffba_pkg::OFF_W;
    localparam int LEN_W  = ffba_pkg::LEN_W;
    localparam int SUM_W  = ffba_pkg::SUM_W;
    localparam int DIFF_W = ffba_pkg::DIFF_W;
    localparam int ADDR_W = ffba_pkg::ADDR_W;
    localparam int USED_W = ffba_pkg::USED_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_LINK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // control and item registers
    state_t                         state_reg, state_next;
    logic                           op_reg, op_next;
    logic [LEN_W-1:0]               size_reg, size_next;
    logic [SUM_W-1:0]               need_reg, need_next;
    logic signed [DIFF_W-1:0]       diff_reg, diff_next;
    logic [IDX_W-1:0]               cur_reg, cur_next;
    logic [SUM_W-1:0]               cur_end_reg, cur_end_next;
    logic [SUM_W-1:0]               thr_reg, thr_next;
    logic [USED_W-1:0]              used_reg, used_next;
    logic [ffba_pkg::MAX_BLOCKS-1:0] lv_reg, lv_next;
    ffba_pkg::status_t              res_status_reg, res_status_next;
    logic [OFF_W-1:0]               res_off_reg, res_off_next;
    logic [LEN_W-1:0]               res_len_reg, res_len_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic [ffba_pkg::STATUS_W-1:0]  out_status_reg;
    logic [ADDR_W-1:0]              out_block_reg;
    logic [ADDR_W-1:0]              out_data_reg;
    logic [LEN_W-1:0]               out_payload_reg;
    logic                           out_load;

    // configuration registers
    logic [ADDR_W-1:0]              heap_base_reg;
    logic [LEN_W-1:0]               head_len_reg;

    // block table memories
    logic [OFF_W+LEN_W-1:0]         data_mem [ffba_pkg::MAX_BLOCKS];
    logic [IDX_W-1:0]               link_mem [ffba_pkg::MAX_BLOCKS];
    logic [OFF_W+LEN_W-1:0]         data_rd_reg;
    logic [IDX_W-1:0]               link_rd_reg;
    logic [IDX_W-1:0]               rd_idx_reg;
    logic [IDX_W-1:0]               rd_addr;
    logic                           data_we;
    logic [OFF_W+LEN_W-1:0]         data_wdata;
    logic                           link_we;
    logic [IDX_W-1:0]               link_waddr;
    logic [IDX_W-1:0]               link_wdata;

    // entry arriving from the memories
    logic [OFF_W-1:0]               e_off;
    logic [LEN_W-1:0]               e_len;
    logic [SUM_W-1:0]               e_end;
    logic [SUM_W-1:0]               e_thr;
    logic                           e_lv;
    logic                           e_fit;
    logic                           e_match;
    logic signed [DIFF_W-1:0]       e_off_s;
    logic signed [DIFF_W-1:0]       e_end_s;
    logic [IDX_W-1:0]               fresh;
    logic                           req_fire;
    logic [ADDR_W-1:0]              emit_addr;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign fresh     = used_reg[IDX_W-1:0];

    // head entry offset is zero and its length lives in a register, not in the data memory
    always_comb
    begin
        if (rd_idx_reg == '0)
        begin
            e_off = '0;
            e_len = head_len_reg;
        end
        else
        begin
            e_off = data_rd_reg[OFF_W+LEN_W-1:LEN_W];
            e_len = data_rd_reg[LEN_W-1:0];
        end
    end

    assign e_end   = SUM_W'(e_off) + SUM_W'(ffba_pkg::HEADER_BYTES) + SUM_W'(e_len);
    assign e_thr   = e_end + need_reg;
    assign e_lv    = lv_reg[rd_idx_reg];
    assign e_fit   = SUM_W'(e_off) >= thr_reg;
    assign e_off_s = $signed(DIFF_W'(e_off));
    assign e_end_s = $signed(DIFF_W'(e_end));
    assign e_match = (diff_reg == e_off_s) || ((diff_reg > e_off_s) && (diff_reg < e_end_s));

    assign rd_addr = (state_reg == S_WALK) ? link_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[fresh] <= data_wdata;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        data_rd_reg <= data_mem[rd_addr];
        link_rd_reg <= link_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        need_next       = need_reg;
        diff_next       = diff_reg;
        cur_next        = cur_reg;
        cur_end_next    = cur_end_reg;
        thr_next        = thr_reg;
        used_next       = used_reg;
        lv_next         = lv_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_len_next    = res_len_reg;
        data_we         = 1'b0;
        data_wdata      = {cur_end_reg[OFF_W-1:0], size_reg};
        link_we         = 1'b0;
        link_waddr      = fresh;
        link_wdata      = rd_idx_reg;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next   = req.operation;
                    size_next = req.request_size;
                    need_next = SUM_W'(ffba_pkg::HEADER_BYTES) + SUM_W'(req.request_size);
                    diff_next = $signed(DIFF_W'(req.query_address))
                                - $signed(DIFF_W'(heap_base_reg));
                    thr_next  = '1;
                    if ((req.operation == ffba_pkg::OP_ALLOC)
                        && (used_reg >= USED_W'(ffba_pkg::MAX_BLOCKS)))
                    begin
                        res_status_next = ffba_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (op_reg == ffba_pkg::OP_FIND)
                begin
                    if (e_match)
                    begin
                        res_status_next = ffba_pkg::ST_OK;
                        res_off_next    = e_off;
                        res_len_next    = e_len;
                        state_next      = S_DONE;
                    end
                    else if (!e_lv)
                    begin
                        res_status_next = ffba_pkg::ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                end
                else if (e_fit)
                begin
                    // gap after cur holds the new block, which links on to this entry
                    data_we         = 1'b1;
                    link_we         = 1'b1;
                    lv_next[fresh]  = 1'b1;
                    res_status_next = ffba_pkg::ST_OK;
                    res_off_next    = cur_end_reg[OFF_W-1:0];
                    res_len_next    = size_reg;
                    state_next      = S_LINK;
                end
                else
                begin
                    cur_next     = rd_idx_reg;
                    cur_end_next = e_end;
                    thr_next     = e_thr;
                    if (!e_lv)
                    begin
                        if (e_thr > SUM_W'(ffba_pkg::HEAP_BYTES))
                        begin
                            res_status_next = ffba_pkg::ST_EXHAUSTED;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // append after the last block
                            data_we         = 1'b1;
                            data_wdata      = {e_end[OFF_W-1:0], size_reg};
                            lv_next[fresh]  = 1'b0;
                            res_status_next = ffba_pkg::ST_OK;
                            res_off_next    = e_end[OFF_W-1:0];
                            res_len_next    = size_reg;
                            state_next      = S_LINK;
                        end
                    end
                end
            end
            S_LINK:
            begin
                link_we          = 1'b1;
                link_waddr       = cur_reg;
                link_wdata       = fresh;
                lv_next[cur_reg] = 1'b1;
                used_next        = used_reg + USED_W'(1);
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign emit_addr = heap_base_reg + ADDR_W'(res_off_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= USED_W'(1);
            lv_reg        <= '0;
            out_valid_reg <= 1'b0;
            heap_base_reg <= '0;
            head_len_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            lv_reg        <= lv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ffba_pkg::CFG_HEAP_BASE:
                    begin
                        heap_base_reg <= cfg_data[ADDR_W-1:0];
                    end
                    ffba_pkg::CFG_HEAD_PAYLOAD:
                    begin
                        head_len_reg <= cfg_data[LEN_W-1:0];
                    end
                    default:
                    begin
                        head_len_reg <= head_len_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        need_reg       <= need_next;
        diff_reg       <= diff_next;
        cur_reg        <= cur_next;
        cur_end_reg    <= cur_end_next;
        thr_reg        <= thr_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_len_reg    <= res_len_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            if (res_status_reg == ffba_pkg::ST_OK)
            begin
                out_block_reg   <= emit_addr;
                out_data_reg    <= emit_addr + ADDR_W'(ffba_pkg::HEADER_BYTES);
                out_payload_reg <= res_len_reg;
            end
            else
            begin
                out_block_reg   <= '0;
                out_data_reg    <= '0;
                out_payload_reg <= '0;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.block_address = out_block_reg;
    assign rsp.data_address  = out_data_reg;
    assign rsp.block_payload = out_payload_reg;

endmodule
`default_nettype wire

// ===== dv/ffba_result_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_result_checker
// Watches the request, response and register ports of the first-fit block
// allocator, keeps its own copy of the block table, works out the answer to
// every accepted request and compares each response beat with the oldest
// answer still due.
// ----------------------------------------------------------------------------
module ffba_result_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ffba_req_if                                  req,
    ffba_rsp_if                                  rsp,
    input  wire logic                            cfg_we,
    input  wire logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                          mismatches,
    output int unsigned                          pending
);

    localparam int ADDR_W       = ffba_pkg::ADDR_W;
    localparam int LEN_W        = ffba_pkg::LEN_W;
    localparam int OFF_W        = ffba_pkg::OFF_W;
    localparam int IDX_W        = ffba_pkg::IDX_W;
    localparam int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS;
    localparam int HEADER_BYTES = ffba_pkg::HEADER_BYTES;
    localparam int HEAP_BYTES   = ffba_pkg::HEAP_BYTES;

    typedef struct packed {
        ffba_pkg::status_t   status;
        logic [ADDR_W-1:0]   block_address;
        logic [ADDR_W-1:0]   data_address;
        logic [LEN_W-1:0]    block_payload;
    } block_answer_t;

    logic [ADDR_W-1:0] base_addr;
    logic [OFF_W-1:0]  off_tab  [MAX_BLOCKS];
    logic [LEN_W-1:0]  len_tab  [MAX_BLOCKS];
    logic [IDX_W-1:0]  link_tab [MAX_BLOCKS];
    logic              link_ok  [MAX_BLOCKS];
    int unsigned       entries_used;
    block_answer_t     answers_due [$];

    function automatic longint unsigned span_end(input int unsigned e);
        return 64'(off_tab[e]) + 64'(HEADER_BYTES) + 64'(len_tab[e]);
    endfunction

    function automatic block_answer_t first_fit_answer(
        input logic              op,
        input logic [LEN_W-1:0]  size,
        input logic [ADDR_W-1:0] query
    );
        block_answer_t     ans;
        int unsigned       cur;
        int unsigned       steps;
        int unsigned       fresh;
        logic              fits;
        logic              found;
        logic              walking;
        longint unsigned   need;
        longint unsigned   nstart;
        longint unsigned   start;
        longint unsigned   hdr;
        longint unsigned   tail;
        longint unsigned   where;
        logic [LEN_W-1:0]  plen;

        ans   = '0;
        cur   = 0;
        steps = 0;
        start = 0;
        plen  = '0;
        if (op == ffba_pkg::OP_ALLOC)
        begin
            if (entries_used >= MAX_BLOCKS)
            begin
                ans.status = ffba_pkg::ST_FULL;
            end
            else
            begin
                fits = 1'b0;
                need = 64'(HEADER_BYTES) + 64'(size);
                while (link_ok[cur] && steps < MAX_BLOCKS && !fits)
                begin
                    nstart = 64'(off_tab[link_tab[cur]]);
                    if (nstart >= span_end(cur) && nstart - span_end(cur) >= need)
                    begin
                        fits = 1'b1;
                    end
                    else
                    begin
                        cur = link_tab[cur];
                        steps++;
                    end
                end
                start = span_end(cur);
                if (!fits && start + need > 64'(HEAP_BYTES))
                begin
                    ans.status = ffba_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    fresh = entries_used;
                    off_tab[fresh] = start[OFF_W-1:0];
                    len_tab[fresh] = size;
                    link_ok[fresh] = fits;
                    if (fits)
                    begin
                        link_tab[fresh] = link_tab[cur];
                    end
                    link_tab[cur] = fresh[IDX_W-1:0];
                    link_ok[cur]  = 1'b1;
                    entries_used++;
                    plen = size;
                end
            end
        end
        else
        begin
            found   = 1'b0;
            walking = 1'b1;
            while (walking)
            begin
                hdr  = 64'(base_addr) + 64'(off_tab[cur]);
                tail = 64'(base_addr) + span_end(cur);
                if (64'(query) >= hdr && 64'(query) < tail)
                begin
                    found   = 1'b1;
                    walking = 1'b0;
                end
                else if (!link_ok[cur] || steps >= MAX_BLOCKS)
                begin
                    walking = 1'b0;
                end
                else
                begin
                    cur = link_tab[cur];
                    steps++;
                end
            end
            if (found)
            begin
                start = 64'(off_tab[cur]);
                plen  = len_tab[cur];
            end
            else
            begin
                ans.status = ffba_pkg::ST_NOT_FOUND;
            end
        end
        if (ans.status == ffba_pkg::ST_OK)
        begin
            where = 64'(base_addr) + start;
            ans.block_address = where[ADDR_W-1:0];
            where = where + 64'(HEADER_BYTES);
            ans.data_address  = where[ADDR_W-1:0];
            ans.block_payload = plen;
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int            i;
        block_answer_t due;
        block_answer_t seen;

        if (!rst_n)
        begin
            base_addr = '0;
            for (i = 0; i < MAX_BLOCKS; i++)
            begin
                off_tab[i]  = '0;
                len_tab[i]  = '0;
                link_tab[i] = '0;
                link_ok[i]  = 1'b0;
            end
            entries_used = 1;
            answers_due.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ffba_pkg::CFG_HEAP_BASE)
                begin
                    base_addr = cfg_data[ADDR_W-1:0];
                end
                else if (cfg_index == ffba_pkg::CFG_HEAD_PAYLOAD)
                begin
                    len_tab[0] = cfg_data[LEN_W-1:0];
                end
            end
            if (req.valid && req.ready)
            begin
                answers_due.push_back(first_fit_answer(req.operation, req.request_size,
                                                       req.query_address));
            end
            if (rsp.valid && rsp.ready)
            begin
                seen.status        = ffba_pkg::status_t'(rsp.status);
                seen.block_address = rsp.block_address;
                seen.data_address  = rsp.data_address;
                seen.block_payload = rsp.block_payload;
                if (answers_due.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected response beat: status %0d block %h",
                                 seen.status, seen.block_address);
                    end
                    mismatches++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (due != seen)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("mismatch (expected/actual): status %0d/%0d",
                                     due.status, seen.status);
                            $display("  block %h/%h data %h/%h payload %0d/%0d",
                                     due.block_address, seen.block_address,
                                     due.data_address, seen.data_address,
                                     due.block_payload, seen.block_payload);
                        end
                        mismatches++;
                    end
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

// ===== dv/first_fit_block_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top_tb
// Drives allocate and find beats into the first-fit block allocator under
// several heap base and head block settings, with random gaps on both sides,
// a long response stall and drained pauses; the result checker predicts and
// compares every response beat.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top_tb;

    localparam int ADDR_W       = ffba_pkg::ADDR_W;
    localparam int LEN_W        = ffba_pkg::LEN_W;
    localparam int CFG_IDX_W    = ffba_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = ffba_pkg::CFG_DATA_W;
    localparam int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS;
    localparam int HEADER_BYTES = ffba_pkg::HEADER_BYTES;
    localparam int HEAP_BYTES   = ffba_pkg::HEAP_BYTES;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           mismatches;
    int unsigned           pending;

    logic [ADDR_W-1:0]     cur_base;
    logic [ADDR_W-1:0]     known_off [$];
    logic [LEN_W-1:0]      known_len [$];
    bit                    steady;
    bit                    hold_request;
    int unsigned           n_alloc;
    int unsigned           n_find;
    int unsigned           tally [4];

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ffba_result_checker answer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 700000);
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] head);
        write_reg(ffba_pkg::CFG_HEAP_BASE, CFG_DATA_W'(base));
        write_reg(ffba_pkg::CFG_HEAD_PAYLOAD, CFG_DATA_W'(head));
        cur_base = base;
    endtask

    task automatic send_beat(input logic op, input logic [LEN_W-1:0] size,
                             input logic [ADDR_W-1:0] query);
        int unsigned gap;

        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.request_size  <= size;
        req_ch.query_address <= query;
        if (op == ffba_pkg::OP_ALLOC)
        begin
            n_alloc++;
        end
        else
        begin
            n_find++;
        end
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
            begin
                break;
            end
        end
        @(negedge clk);
    endtask

    // pause the sender until every response beat has come back
    task automatic drain;
        req_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
    endtask

    task automatic run_mix(input int unsigned count, input int unsigned alloc_pct);
        logic [LEN_W-1:0]  size;
        logic [ADDR_W-1:0] query;
        logic [ADDR_W-1:0] hdr;
        logic [ADDR_W-1:0] span;
        int unsigned       roll;
        int unsigned       k;

        repeat (count)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                steady = ~steady;
            end
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                roll = $urandom_range(0, 15);
                if (roll == 0)
                    size = LEN_W'(HEAP_BYTES);
                else if (roll <= 2)
                    size = LEN_W'($urandom_range(0, HEAP_BYTES));
                else if (roll <= 4)
                    size = LEN_W'($urandom_range(0, 31));
                else
                    size = LEN_W'($urandom_range(0, 6000));
                send_beat(ffba_pkg::OP_ALLOC, size, $urandom);
            end
            else
            begin
                roll = $urandom_range(0, 15);
                if (roll == 0 || known_off.size() == 0)
                begin
                    query = $urandom;
                end
                else if (roll <= 2)
                begin
                    query = cur_base + ADDR_W'($urandom_range(0, HEAP_BYTES + 64));
                end
                else if (roll == 3)
                begin
                    query = cur_base;
                end
                else
                begin
                    k    = $urandom_range(0, known_off.size() - 1);
                    hdr  = cur_base + known_off[k];
                    span = ADDR_W'(HEADER_BYTES) + ADDR_W'(known_len[k]);
                    case ($urandom_range(0, 4))
                        0: query = hdr;
                        1: query = hdr - 1;
                        2: query = hdr + span - 1;
                        3: query = hdr + span;
                        default: query = hdr + ADDR_W'($urandom_range(0, span));
                    endcase
                end
                send_beat(ffba_pkg::OP_FIND, LEN_W'($urandom_range(0, HEAP_BYTES)), query);
            end
        end
    endtask

    // response side: random stalls, one long hold-off on request
    initial
    begin : response_side
        int unsigned stall;

        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (rsp_ch.valid)
                begin
                    break;
                end
            end
            tally[rsp_ch.status]++;
            if (rsp_ch.status == ffba_pkg::ST_OK)
            begin
                known_off.push_back(rsp_ch.block_address - cur_base);
                known_len.push_back(rsp_ch.block_payload);
                if (known_off.size() > 64)
                begin
                    void'(known_off.pop_front());
                    void'(known_len.pop_front());
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        req_ch.valid         = 1'b0;
        req_ch.operation     = ffba_pkg::OP_ALLOC;
        req_ch.request_size  = '0;
        req_ch.query_address = '0;
        cfg_we       = 1'b0;
        cfg_index    = ffba_pkg::CFG_HEAP_BASE;
        cfg_data     = '0;
        rst_n        = 1'b0;
        steady       = 1'b0;
        hold_request = 1'b0;
        cur_base     = '0;
        n_alloc      = 0;
        n_find       = 0;
        foreach (tally[i])
        begin
            tally[i] = 0;
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // head block ends one header short of the heap end
        configure('0, LEN_W'(HEAP_BYTES - 2 * HEADER_BYTES));
        send_beat(ffba_pkg::OP_FIND, '0, '0);
        send_beat(ffba_pkg::OP_FIND, '0, ADDR_W'(HEAP_BYTES - HEADER_BYTES - 1));
        send_beat(ffba_pkg::OP_FIND, '0, ADDR_W'(HEAP_BYTES - HEADER_BYTES));
        send_beat(ffba_pkg::OP_FIND, LEN_W'(HEAP_BYTES), '1);
        send_beat(ffba_pkg::OP_ALLOC, LEN_W'(1), '0);
        send_beat(ffba_pkg::OP_ALLOC, '0, '0);
        send_beat(ffba_pkg::OP_FIND, '0, ADDR_W'(HEAP_BYTES - HEADER_BYTES));
        send_beat(ffba_pkg::OP_ALLOC, '0, '1);
        send_beat(ffba_pkg::OP_ALLOC, LEN_W'(HEAP_BYTES), '0);
        drain;

        // top of the address space, head block over the whole heap
        configure('1, LEN_W'(HEAP_BYTES));
        send_beat(ffba_pkg::OP_FIND, '0, '1);
        send_beat(ffba_pkg::OP_FIND, '0, '0);
        send_beat(ffba_pkg::OP_ALLOC, LEN_W'(5), '0);
        drain;

        // shrink the head to open a gap before the last block
        configure(32'hA5A5_0000, LEN_W'(500000));
        send_beat(ffba_pkg::OP_ALLOC, LEN_W'(548505), '0);
        send_beat(ffba_pkg::OP_ALLOC, '0, '0);
        send_beat(ffba_pkg::OP_FIND, '0, 32'hA5A5_0000 + 32'd500024);
        send_beat(ffba_pkg::OP_FIND, '0, 32'hA5A5_0000 + 32'd500047);
        send_beat(ffba_pkg::OP_FIND, '0, 32'hA5A5_0000 + 32'd500048);
        send_beat(ffba_pkg::OP_FIND, '0, 32'hA5A5_0000 + ADDR_W'(HEAP_BYTES - 1));
        send_beat(ffba_pkg::OP_FIND, '0, 32'hA5A5_0000 - 32'd1);

        run_mix(250, 8);
        drain;

        // empty head opens a second gap in front
        configure($urandom, '0);
        run_mix(120, 8);
        hold_request = 1'b1;
        run_mix(250, 8);
        drain;

        configure($urandom, LEN_W'($urandom_range(0, HEAP_BYTES)));
        run_mix(150, 12);
        drain;
        run_mix(150, 12);
        drain;

        configure('0, '0);
        run_mix(400, 15);
        drain;

        configure('1, LEN_W'(HEAP_BYTES));
        run_mix(300, 10);
        drain;
        repeat (MAX_BLOCKS + 8) @(negedge clk);

        $display("ran %0d allocate and %0d find beats over seven register settings",
                 n_alloc, n_find);
        $display("responses: %0d ok, %0d not found, %0d table full, %0d heap exhausted",
                 tally[ffba_pkg::ST_OK], tally[ffba_pkg::ST_NOT_FOUND],
                 tally[ffba_pkg::ST_FULL], tally[ffba_pkg::ST_EXHAUSTED]);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== first_fit_block_allocator_top.f =====
rtl/ffba_pkg.sv
rtl/ffba_req_if.sv
rtl/ffba_rsp_if.sv
rtl/first_fit_block_allocator_top.sv
dv/ffba_result_checker.sv
dv/first_fit_block_allocator_top_tb.sv
